@@ sv/call_arc_count_table_unit_macros.svh @@
// Assertion macros used by the arc count table top level.
`ifndef CALL_ARC_COUNT_TABLE_UNIT_MACROS_SVH
`define CALL_ARC_COUNT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CATU_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("arc table assertion failed");

// Next-cycle implication, off while reset is high.
`define CATU_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("arc table assertion failed");

`endif

@@ sv/catu_pkg.sv @@
// Types, codes and defaults for the call arc count table.
`timescale 1ns / 1ps
package catu_pkg;

   localparam int BUCKETS_DEFAULT = 4096;
   localparam int ARCS_DEFAULT    = 1024;
   localparam int PC_BITS         = 32;
   localparam int IDX_BITS        = 10;

   localparam logic [1:0] OP_RECORD      = 2'd0;
   localparam logic [1:0] OP_READ_ARC    = 2'd1;
   localparam logic [1:0] OP_READ_BUCKET = 2'd2;

   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_RANGE    = 3'd1;
   localparam logic [2:0] ST_NEW      = 3'd2;
   localparam logic [2:0] ST_HEAD_HIT = 3'd3;
   localparam logic [2:0] ST_MOVED    = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;
   localparam logic [2:0] ST_READ     = 3'd6;

   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_LOW_PC    = 2'd1;
   localparam logic [1:0] CSR_TEXT_SIZE = 2'd2;
   localparam logic [1:0] CSR_ARC_LIMIT = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_BKT, S_HCHK, S_WALK, S_MOVE,
      S_ALLOC, S_RDBKT, S_RDARC, S_DONE
   } catu_state_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_CLEAR, DP_ACCEPT, DP_BKT_RD_REC, DP_BKT_RD_IDX,
      DP_ARC_RD_IDX, DP_ARC_RD_BKT, DP_ARC_RD_HEAD, DP_HEAD_HIT,
      DP_WALK_STEP, DP_MOVE1, DP_MOVE2, DP_ALLOC, DP_OVERFLOW,
      DP_BLANK, DP_EMIT_READ
   } catu_act_type;

   typedef struct packed {
      logic         req_ready;
      catu_act_type act;
      logic [2:0]   blank_st;
      logic         load_out;
   } catu_cmd_type;

   typedef struct packed {
      logic       clr_done;
      logic       req_valid;
      logic [1:0] op;
      logic       not_en;
      logic       rec_oor;
      logic       arc_oor;
      logic       bkt_oor;
      logic       bkt_zero;
      logic       match;
      logic       next_zero;
      logic       overflow;
      logic       out_free;
   } catu_sts_type;

endpackage

@@ sv/catu_req_if.sv @@
// Request channel: record and read words.
`timescale 1ns / 1ps
interface catu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] caller_pc;
   logic [31:0] callee_pc;
   logic [11:0] read_index;

   modport source (output valid, output opcode, output caller_pc, output callee_pc,
                   output read_index, input ready);
   modport sink (input valid, input opcode, input caller_pc, input callee_pc,
                 input read_index, output ready);
endinterface

@@ sv/catu_rsp_if.sv @@
// Response channel: one result word per request.
`timescale 1ns / 1ps
interface catu_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [9:0]  entry_index;
   logic [31:0] entry_pc;
   logic [31:0] entry_count;
   logic [9:0]  entry_link;

   modport source (output valid, output status, output entry_index, output entry_pc,
                   output entry_count, output entry_link, input ready);
   modport sink (input valid, input status, input entry_index, input entry_pc,
                 input entry_count, input entry_link, output ready);
endinterface

@@ sv/catu_ctrl.sv @@
// Sequencer for record and read operations.
`timescale 1ns / 1ps
module catu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  catu_pkg::catu_sts_type sts,
   output catu_pkg::catu_cmd_type cmd
);
   import catu_pkg::*;

   catu_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.act      = DP_NONE;
      cmd.blank_st = ST_IGNORED;
      case (state_ff)
         S_CLEAR: begin
            cmd.act = DP_CLEAR;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.act       = DP_ACCEPT;
            if (sts.req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_DONE;
            cmd.act  = DP_BLANK;
            case (sts.op)
               OP_RECORD: begin
                  if (sts.not_en) begin
                     cmd.blank_st = ST_IGNORED;
                  end else if (sts.rec_oor) begin
                     cmd.blank_st = ST_RANGE;
                  end else begin
                     cmd.act  = DP_BKT_RD_REC;
                     state_in = S_BKT;
                  end
               end
               OP_READ_ARC: begin
                  if (sts.arc_oor) begin
                     cmd.blank_st = ST_RANGE;
                  end else begin
                     cmd.act  = DP_ARC_RD_IDX;
                     state_in = S_RDARC;
                  end
               end
               OP_READ_BUCKET: begin
                  if (sts.bkt_oor) begin
                     cmd.blank_st = ST_RANGE;
                  end else begin
                     cmd.act  = DP_BKT_RD_IDX;
                     state_in = S_RDBKT;
                  end
               end
               default: cmd.blank_st = ST_IGNORED;
            endcase
         end
         S_BKT: begin
            cmd.act  = DP_ARC_RD_HEAD;
            state_in = sts.bkt_zero ? S_ALLOC : S_HCHK;
         end
         S_HCHK: begin
            if (sts.match) begin
               cmd.act  = DP_HEAD_HIT;
               state_in = S_DONE;
            end else begin
               cmd.act  = DP_WALK_STEP;
               state_in = sts.next_zero ? S_ALLOC : S_WALK;
            end
         end
         S_WALK: begin
            if (sts.match) begin
               cmd.act  = DP_MOVE1;
               state_in = S_MOVE;
            end else begin
               cmd.act  = DP_WALK_STEP;
               state_in = sts.next_zero ? S_ALLOC : S_WALK;
            end
         end
         S_MOVE: begin
            cmd.act  = DP_MOVE2;
            state_in = S_DONE;
         end
         S_ALLOC: begin
            cmd.act  = sts.overflow ? DP_OVERFLOW : DP_ALLOC;
            state_in = S_DONE;
         end
         S_RDBKT: begin
            state_in = S_DONE;
            if (sts.bkt_zero) begin
               cmd.act      = DP_BLANK;
               cmd.blank_st = ST_READ;
            end else begin
               cmd.act  = DP_ARC_RD_BKT;
               state_in = S_RDARC;
            end
         end
         S_RDARC: begin
            cmd.act  = DP_EMIT_READ;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

@@ sv/catu_dpath.sv @@
// Datapath: config registers, bucket and arc memories, result registers.
`timescale 1ns / 1ps
module catu_dpath #(
   parameter int BUCKETS = catu_pkg::BUCKETS_DEFAULT,
   parameter int ARCS    = catu_pkg::ARCS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   catu_req_if.sink               req_ch,
   catu_rsp_if.source             rsp_ch,
   input  catu_pkg::catu_cmd_type cmd,
   output catu_pkg::catu_sts_type sts
);
   import catu_pkg::*;

   localparam int BW = $clog2(BUCKETS);
   localparam int AW = $clog2(ARCS);

   // configuration
   logic        enable_ff;
   logic [31:0] low_pc_ff;
   logic [13:0] text_size_ff;
   logic [10:0] arc_limit_ff;

   // control state
   logic          halted_ff;
   logic [AW-1:0] last_ff;
   logic [BW-1:0] clr_cnt_ff;
   logic          rsp_valid_ff;

   // item registers
   logic [1:0]    op_ff;
   logic [31:0]   off_ff;
   logic [31:0]   callee_ff;
   logic [11:0]   ri_ff;
   logic [BW-1:0] b_ff;
   logic [AW-1:0] head_ff, prev_ff, cur_ff, rd_idx_ff;

   // result staging and output
   logic [2:0]  res_st_ff, out_st_ff;
   logic [9:0]  res_idx_ff, out_idx_ff, res_link_ff, out_link_ff;
   logic [31:0] res_pc_ff, out_pc_ff, res_cnt_ff, out_cnt_ff;

   // memories
   logic [AW-1:0] bkt_mem [BUCKETS];
   logic [31:0]   callee_mem [ARCS];
   logic [31:0]   tally_mem [ARCS];
   logic [AW-1:0] next_mem [ARCS];
   logic [AW-1:0] bkt_q_ff;
   logic [31:0]   callee_q_ff, tally_q_ff;
   logic [AW-1:0] next_q_ff;

   logic          bkt_we;
   logic [BW-1:0] bkt_waddr, bkt_raddr;
   logic [AW-1:0] bkt_wdata;
   logic          callee_we, tally_we, next_we;
   logic [AW-1:0] callee_waddr, tally_waddr, next_waddr, next_wdata, arc_raddr;
   logic [31:0]   callee_wdata, tally_wdata;

   logic [31:0]   bumped, limit32, alloc32;
   logic [AW-1:0] alloc_idx;

   assign bumped    = (tally_q_ff == 32'hFFFF_FFFF) ? tally_q_ff : tally_q_ff + 32'd1;
   assign limit32   = (32'(arc_limit_ff) < 32'(ARCS)) ? 32'(arc_limit_ff) : 32'(ARCS);
   assign alloc32   = 32'(last_ff) + 32'd1;
   assign alloc_idx = AW'(alloc32);

   assign sts.clr_done  = (clr_cnt_ff == BW'(BUCKETS - 1));
   assign sts.req_valid = req_ch.valid;
   assign sts.op        = op_ff;
   assign sts.not_en    = !enable_ff || halted_ff;
   assign sts.rec_oor   = (off_ff >= 32'(text_size_ff)) || ((off_ff >> 1) >= 32'(BUCKETS));
   assign sts.arc_oor   = 32'(ri_ff) >= 32'(ARCS);
   assign sts.bkt_oor   = 32'(ri_ff) >= 32'(BUCKETS);
   assign sts.bkt_zero  = (bkt_q_ff == '0);
   assign sts.match     = (callee_q_ff == callee_ff);
   assign sts.next_zero = (next_q_ff == '0);
   assign sts.overflow  = alloc32 >= limit32;
   assign sts.out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready      = cmd.req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = out_st_ff;
   assign rsp_ch.entry_index = out_idx_ff;
   assign rsp_ch.entry_pc   = out_pc_ff;
   assign rsp_ch.entry_count = out_cnt_ff;
   assign rsp_ch.entry_link = out_link_ff;

   // memory port selection
   always_comb begin
      bkt_we       = 1'b0;
      bkt_waddr    = b_ff;
      bkt_wdata    = cur_ff;
      bkt_raddr    = off_ff[BW:1];
      callee_we    = 1'b0;
      callee_waddr = alloc_idx;
      callee_wdata = callee_ff;
      tally_we     = 1'b0;
      tally_waddr  = cur_ff;
      tally_wdata  = bumped;
      next_we      = 1'b0;
      next_waddr   = prev_ff;
      next_wdata   = next_q_ff;
      arc_raddr    = cur_ff;
      case (cmd.act)
         DP_CLEAR: begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_cnt_ff;
            bkt_wdata = '0;
         end
         DP_BKT_RD_IDX:  bkt_raddr = BW'(ri_ff);
         DP_ARC_RD_IDX:  arc_raddr = AW'(ri_ff);
         DP_ARC_RD_BKT,
         DP_ARC_RD_HEAD: arc_raddr = bkt_q_ff;
         DP_WALK_STEP:   arc_raddr = next_q_ff;
         DP_HEAD_HIT:    tally_we = 1'b1;
         DP_MOVE1: begin
            tally_we = 1'b1;
            next_we  = 1'b1;
         end
         DP_MOVE2: begin
            next_we    = 1'b1;
            next_waddr = cur_ff;
            next_wdata = head_ff;
            bkt_we     = 1'b1;
         end
         DP_ALLOC: begin
            callee_we   = 1'b1;
            tally_we    = 1'b1;
            tally_waddr = alloc_idx;
            tally_wdata = 32'd1;
            next_we     = 1'b1;
            next_waddr  = alloc_idx;
            next_wdata  = head_ff;
            bkt_we      = 1'b1;
            bkt_wdata   = alloc_idx;
         end
         default: bkt_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wdata;
      bkt_q_ff <= bkt_mem[bkt_raddr];
   end

   always_ff @(posedge clock) begin
      if (callee_we) callee_mem[callee_waddr] <= callee_wdata;
      if (tally_we) tally_mem[tally_waddr] <= tally_wdata;
      if (next_we) next_mem[next_waddr] <= next_wdata;
      callee_q_ff <= callee_mem[arc_raddr];
      tally_q_ff  <= tally_mem[arc_raddr];
      next_q_ff   <= next_mem[arc_raddr];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         low_pc_ff    <= '0;
         text_size_ff <= 14'd8192;
         arc_limit_ff <= 11'd1024;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_LOW_PC:    low_pc_ff    <= csr_wdata;
            CSR_TEXT_SIZE: text_size_ff <= csr_wdata[13:0];
            CSR_ARC_LIMIT: arc_limit_ff <= csr_wdata[10:0];
            default:       enable_ff    <= enable_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff    <= 1'b0;
         last_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.act == DP_CLEAR) clr_cnt_ff <= clr_cnt_ff + BW'(1);
         if (cmd.act == DP_OVERFLOW) halted_ff <= 1'b1;
         if (cmd.act == DP_ALLOC) last_ff <= alloc_idx;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result registers
   always_ff @(posedge clock) begin
      case (cmd.act)
         DP_ACCEPT: begin
            if (req_ch.valid) begin
               op_ff     <= req_ch.opcode;
               off_ff    <= req_ch.caller_pc - low_pc_ff;
               callee_ff <= req_ch.callee_pc;
               ri_ff     <= req_ch.read_index;
            end
         end
         DP_BKT_RD_REC: b_ff <= off_ff[BW:1];
         DP_ARC_RD_IDX: rd_idx_ff <= AW'(ri_ff);
         DP_ARC_RD_BKT: rd_idx_ff <= bkt_q_ff;
         DP_ARC_RD_HEAD: begin
            head_ff <= bkt_q_ff;
            cur_ff  <= bkt_q_ff;
         end
         DP_WALK_STEP: begin
            prev_ff <= cur_ff;
            cur_ff  <= next_q_ff;
         end
         DP_HEAD_HIT: begin
            res_st_ff   <= ST_HEAD_HIT;
            res_idx_ff  <= IDX_BITS'(cur_ff);
            res_pc_ff   <= callee_q_ff;
            res_cnt_ff  <= bumped;
            res_link_ff <= IDX_BITS'(next_q_ff);
         end
         DP_MOVE1: begin
            res_st_ff   <= ST_MOVED;
            res_idx_ff  <= IDX_BITS'(cur_ff);
            res_pc_ff   <= callee_q_ff;
            res_cnt_ff  <= bumped;
            res_link_ff <= IDX_BITS'(head_ff);
         end
         DP_ALLOC: begin
            res_st_ff   <= ST_NEW;
            res_idx_ff  <= IDX_BITS'(alloc_idx);
            res_pc_ff   <= callee_ff;
            res_cnt_ff  <= 32'd1;
            res_link_ff <= IDX_BITS'(head_ff);
         end
         DP_OVERFLOW: begin
            res_st_ff   <= ST_OVERFLOW;
            res_idx_ff  <= '0;
            res_pc_ff   <= '0;
            res_cnt_ff  <= '0;
            res_link_ff <= '0;
         end
         DP_BLANK: begin
            res_st_ff   <= cmd.blank_st;
            res_idx_ff  <= '0;
            res_pc_ff   <= '0;
            res_cnt_ff  <= '0;
            res_link_ff <= '0;
         end
         DP_EMIT_READ: begin
            // entry zero is reserved and reads as empty
            res_st_ff  <= ST_READ;
            res_idx_ff <= IDX_BITS'(rd_idx_ff);
            if (rd_idx_ff == '0) begin
               res_pc_ff   <= '0;
               res_cnt_ff  <= '0;
               res_link_ff <= '0;
            end else begin
               res_pc_ff   <= callee_q_ff;
               res_cnt_ff  <= tally_q_ff;
               res_link_ff <= IDX_BITS'(next_q_ff);
            end
         end
         default: b_ff <= b_ff;
      endcase
      if (cmd.load_out) begin
         out_st_ff   <= res_st_ff;
         out_idx_ff  <= res_idx_ff;
         out_pc_ff   <= res_pc_ff;
         out_cnt_ff  <= res_cnt_ff;
         out_link_ff <= res_link_ff;
      end
   end

endmodule

@@ sv/call_arc_count_table_unit.sv @@
// Top level of the call arc count table.
//
//   channel   dir   handshake      carries
//   req_ch    in    valid/ready    opcode, caller_pc, callee_pc, read_index
//   rsp_ch    out   valid/ready    status, entry_index, entry_pc, entry_count, entry_link
//   csr_*     in    write enable   csr_index, csr_wdata
//
// One word at a time. An ignored or out-of-range word goes from decode to done; an entry
// read reads the arc memory; a bucket read the bucket memory and, unless it is empty, the
// arc memory. A record reads the bucket, checks the chain head and walks the chain (one
// arc memory read a cycle), moves a later hit to front, or adds an arc. The next word is
// taken in the cycle after the result loads. After reset the bucket memory is cleared one
// entry a cycle, all BUCKETS, req_ch.ready low; a stalled result holds the done state.
`timescale 1ns / 1ps
`include "call_arc_count_table_unit_macros.svh"
module call_arc_count_table_unit #(
   parameter int BUCKETS = catu_pkg::BUCKETS_DEFAULT,
   parameter int ARCS    = catu_pkg::ARCS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   catu_req_if.sink    req_ch,
   catu_rsp_if.source  rsp_ch
);
   import catu_pkg::*;

   catu_cmd_type cmd;
   catu_sts_type sts;

   catu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   catu_dpath #(
      .BUCKETS (BUCKETS),
      .ARCS    (ARCS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .cmd       (cmd),
      .sts       (sts)
   );

   `CATU_ASSERT_NEXT(a_one_word, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `CATU_ASSERT_IMPLY(a_clear_blocks, clock, reset, cmd.act == DP_CLEAR, !req_ch.ready)
   `CATU_ASSERT_IMPLY(a_load_free, clock, reset, cmd.load_out, sts.out_free)
   `CATU_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_out, rsp_ch.valid)

endmodule
